// File: hw/rtl/sha1_schedule_block_scrambler_macros.svh
// assertion macros for the sha1 schedule block scrambler
// included by the modules that carry concurrent checks, no other dependencies
`ifndef SHA1_SCHEDULE_BLOCK_SCRAMBLER_MACROS_SVH
`define SHA1_SCHEDULE_BLOCK_SCRAMBLER_MACROS_SVH

`ifndef NO_ASSERTIONS
// property must hold at every clock edge outside reset
`define SBS_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("%m: assertion failed");
// condition must never be true outside reset
`define SBS_NEVER(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("%m: forbidden condition seen");
`else
`define SBS_ASSERT(label, clk, rst_n, prop)
`define SBS_NEVER(label, clk, rst_n, cond)
`endif

`endif

// File: hw/rtl/sha1sbs_pkg.sv
// shared types, constants and helpers for the sha1 schedule block scrambler
// no dependencies
`timescale 1ns / 1ps

package sha1sbs_pkg;

	localparam int BLOCK_WORDS = 16;
	localparam int EXP_ROUNDS  = 64;
	localparam int BLOCK_BYTES = 64;
	localparam int FIFO_DEPTH  = 4;
	localparam int FIFO_AW     = $clog2(FIFO_DEPTH);

	typedef logic [31:0] word_t;
	typedef logic [5:0]  cnt_t;

	localparam cnt_t CNT_LAST_WORD  = cnt_t'(BLOCK_WORDS - 1);
	localparam cnt_t CNT_LAST_ROUND = cnt_t'(EXP_ROUNDS - 1);
	localparam cnt_t CNT_LAST_BYTE  = cnt_t'(BLOCK_BYTES - 1);

	// packer to queue
	typedef struct packed {
		logic  push;
		word_t word;
	} word_push_t;

	// queue head as seen by the back end
	typedef struct packed {
		logic  avail;
		word_t word;
	} word_head_t;

	function automatic word_t rotl1(input word_t v);
		return {v[30:0], v[31]};
	endfunction

endpackage

// File: hw/rtl/sha1_schedule_block_scrambler.sv
// each 64-byte block: a load of sixteen words, 64 rounds and 64 byte emits; with steady input
//   the load waits on the input after four queued words
// the packer keeps taking bytes into a four-word queue while the window is busy
// reset: arst_n low clears byte position, queue pointers, state and output valid
// top level; depends on sha1sbs_pkg, sha1sbs_packer, sha1sbs_fifo, sha1sbs_expander
`timescale 1ns / 1ps

module sha1_schedule_block_scrambler
	import sha1sbs_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] in_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_byte,
	output logic       out_last
);

	word_push_t push;
	word_head_t head;
	logic       fifo_full;
	logic       pop;

	sha1sbs_packer u_packer (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_byte   (in_byte),
		.fifo_full (fifo_full),
		.push      (push)
	);

	sha1sbs_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.pop    (pop),
		.full   (fifo_full),
		.head   (head)
	);

	sha1sbs_expander u_expander (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_byte  (out_byte),
		.out_last  (out_last)
	);

endmodule

// File: hw/rtl/sha1sbs_packer.sv
// front end: takes block bytes and packs them into big-endian words
// depends on sha1sbs_pkg
`timescale 1ns / 1ps

module sha1sbs_packer
	import sha1sbs_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] in_byte,
	input  logic       fifo_full,
	output word_push_t push
);

	logic [1:0]  lane_q;
	logic [23:0] part_q;
	logic        accept;

	// only the byte that completes a word needs queue space
	assign in_stall = (lane_q == 2'd3) && fifo_full;
	assign accept   = in_valid && !in_stall;

	assign push.push = accept && (lane_q == 2'd3);
	assign push.word = {part_q, in_byte};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lane_q <= 2'd0;
		end else if (accept) begin
			lane_q <= lane_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			part_q <= {part_q[15:0], in_byte};
		end
	end

endmodule

// File: hw/rtl/sha1sbs_fifo.sv
// short word queue between the packer and the expansion back end
// depends on sha1sbs_pkg and the assertion macro header
`timescale 1ns / 1ps
`include "sha1_schedule_block_scrambler_macros.svh"

module sha1sbs_fifo
	import sha1sbs_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  word_push_t push,
	input  logic       pop,
	output logic       full,
	output word_head_t head
);

	word_t              mem_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wr_ptr_q;
	logic [FIFO_AW-1:0] rd_ptr_q;
	logic [FIFO_AW:0]   count_q;

	assign full       = (count_q == (FIFO_AW + 1)'(FIFO_DEPTH));
	assign head.avail = (count_q != '0);
	assign head.word  = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push.push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push.push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push.push) begin
			mem_q[wr_ptr_q] <= push.word;
		end
	end

	`SBS_NEVER(a_no_push_when_full, clk, arst_n, push.push && full)
	`SBS_NEVER(a_no_pop_when_empty, clk, arst_n, pop && !head.avail)
	`SBS_ASSERT(a_count_bounded, clk, arst_n, count_q <= (FIFO_AW + 1)'(FIFO_DEPTH))

endmodule

// File: hw/rtl/sha1sbs_expander.sv
// back end: loads sixteen words, runs the 64 schedule rounds, emits 64 bytes
// depends on sha1sbs_pkg and the assertion macro header
`timescale 1ns / 1ps
`include "sha1_schedule_block_scrambler_macros.svh"

module sha1sbs_expander
	import sha1sbs_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  word_head_t head,
	output logic       pop,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_byte,
	output logic       out_last
);

	typedef enum logic [1:0] {
		ST_LOAD,
		ST_EXPAND,
		ST_EMIT
	} state_t;

	state_t     state_q;
	cnt_t       cnt_q;
	logic       out_valid_q;
	logic [7:0] out_byte_q;
	logic       out_last_q;
	word_t      win_q [BLOCK_WORDS];
	logic       emit_go;
	word_t      round_word;
	logic [7:0] sel_byte;

	assign pop     = (state_q == ST_LOAD) && head.avail;
	assign emit_go = (state_q == ST_EMIT) && (!out_valid_q || !out_stall);

	// oldest word sits at index 0, so offsets -3, -8, -14, -16 land on 13, 8, 2, 0
	assign round_word = rotl1(win_q[13] ^ win_q[8] ^ win_q[2] ^ win_q[0]);

	// words leave little-endian: low byte first
	assign sel_byte = win_q[0][{cnt_q[1:0], 3'b000} +: 8];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_LOAD;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
			out_byte_q  <= '0;
			out_last_q  <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
				out_last_q  <= 1'b0;
			end
			case (state_q)
				ST_LOAD: begin
					if (pop) begin
						if (cnt_q == CNT_LAST_WORD) begin
							state_q <= ST_EXPAND;
							cnt_q   <= '0;
						end else begin
							cnt_q <= cnt_q + 1'b1;
						end
					end
				end
				ST_EXPAND: begin
					if (cnt_q == CNT_LAST_ROUND) begin
						state_q <= ST_EMIT;
						cnt_q   <= '0;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_EMIT: begin
					if (emit_go) begin
						out_valid_q <= 1'b1;
						out_byte_q  <= sel_byte;
						out_last_q  <= (cnt_q == CNT_LAST_BYTE);
						if (cnt_q == CNT_LAST_BYTE) begin
							state_q <= ST_LOAD;
							cnt_q   <= '0;
						end else begin
							cnt_q <= cnt_q + 1'b1;
						end
					end
				end
				default: begin
					state_q <= ST_LOAD;
					cnt_q   <= '0;
				end
			endcase
		end
	end

	// rolling window: every move shifts one word toward index 0
	always_ff @(posedge clk) begin
		if (pop || (state_q == ST_EXPAND) || (emit_go && (cnt_q[1:0] == 2'd3))) begin
			for (int i = 0; i < BLOCK_WORDS - 1; i++) begin
				win_q[i] <= win_q[i + 1];
			end
			if (pop) begin
				win_q[BLOCK_WORDS - 1] <= head.word;
			end else if (state_q == ST_EXPAND) begin
				win_q[BLOCK_WORDS - 1] <= round_word;
			end else begin
				win_q[BLOCK_WORDS - 1] <= win_q[0];
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign out_last  = out_last_q;

	`SBS_NEVER(a_last_needs_valid, clk, arst_n, out_last_q && !out_valid_q)
	`SBS_NEVER(a_pop_only_in_load, clk, arst_n, pop && (state_q != ST_LOAD))
	`SBS_ASSERT(a_last_byte_ends_block, clk, arst_n,
		(emit_go && (cnt_q == CNT_LAST_BYTE)) |=> ((state_q == ST_LOAD) && (cnt_q == '0) && out_last_q))

endmodule
